/* hdl/ugns_pkg.sv */
// Shared types, codes and field widths of the uniform grid neighbor search core.
package ugns_pkg;

   localparam int ID_W    = 16;
   localparam int POS_W   = 24;
   localparam int RAD_W   = 23;
   localparam int RR_W    = 2 * RAD_W;
   localparam int DVD_W   = 26;
   localparam int REQ_W   = 112;
   localparam int RSP_W   = 24;
   localparam int Q_DEPTH = 2;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_HIT         = 3'd1;
   localparam logic [2:0] ST_NO_HITS     = 3'd2;
   localparam logic [2:0] ST_FULL        = 3'd3;
   localparam logic [2:0] ST_OUTSIDE     = 3'd4;
   localparam logic [2:0] ST_NOT_PRESENT = 3'd5;
   localparam logic [2:0] ST_TRUNCATED   = 3'd6;

   localparam logic [2:0] CSR_MIN_X = 3'd0;
   localparam logic [2:0] CSR_MIN_Y = 3'd1;
   localparam logic [2:0] CSR_MIN_Z = 3'd2;
   localparam logic [2:0] CSR_MAX_X = 3'd3;
   localparam logic [2:0] CSR_MAX_Y = 3'd4;
   localparam logic [2:0] CSR_MAX_Z = 3'd5;
   localparam logic [2:0] CSR_EDGE  = 3'd6;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ID_W-1:0]  particle_id;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [RAD_W-1:0] search_radius;
      logic [RR_W-1:0]  radius_sq;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0]  particle_id;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
   } entry_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0] grid_min;
      logic [2:0][POS_W-1:0] grid_max;
      logic [RAD_W-1:0]      cell_edge;
   } cfg_type;

   typedef enum logic [1:0] {
      PH_SPAN,
      PH_LO,
      PH_HI
   } phase_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_ROUTE,
      S_CELL_A,
      S_CELL_B,
      S_FILL_RD,
      S_FILL_CHK,
      S_REM_RD,
      S_REM_CMP,
      S_REM_MOVE,
      S_QRY_RD,
      S_QRY_DIFF,
      S_QRY_SQ,
      S_QRY_SUM,
      S_QRY_CMP,
      S_QRY_EMIT,
      S_QRY_ADV,
      S_QRY_NEXT,
      S_QRY_END,
      S_RESULT
   } back_state_type;

endpackage

/* hdl/uniform_grid_neighbor_search_core.sv */
// Top level of the uniform grid neighbor search core.
//
//   Channel   Direction  Transaction
//   req_*     in         one insert, remove or range query request
//   rsp_*     out        one result; tlast marks the final result of a request
//   csr_*     in         one configuration register write, no handshake
//
// Every divide is done by one shared bit-serial divider.
// An insert or remove runs six divides (three axis spans, three cell
// coordinates) plus bucket memory accesses. A query runs nine divides,
// then visits each covered cell and compares each stored entry in it; a
// result waiting on rsp_tready holds it up.
// After reset the bucket fill counts are cleared one cell per cycle;
// req_tready stays low until that pass ends.
// Up to three requests are buffered ahead of the back end, so requests keep
// flowing in while a result waits on rsp_tready.
module uniform_grid_neighbor_search_core #(
   parameter int CELLS_PER_AXIS = 16,
   parameter int BUCKET_CAP     = 8,
   parameter int MAX_HITS       = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // req_tdata, low to high: particle_id[15:0], pos_x[39:16], pos_y[63:40],
   // pos_z[87:64], search_radius[110:88], zero pad
   input  logic [ugns_pkg::REQ_W-1:0] req_tdata,
   // req_tuser: kind[1:0]
   input  logic [1:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // rsp_tdata, low to high: found_id[15:0], status[18:16], zero pad
   output logic [ugns_pkg::RSP_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [ugns_pkg::POS_W-1:0] csr_wr_data
);

   // Grid configuration; the user must write it only while the core is idle, the core does not enforce this.
   ugns_pkg::cfg_type cfg_ff, cfg_in;

   logic               q_push, q_pop, q_full, q_empty;
   logic               clear_done;
   ugns_pkg::item_type push_item, head_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ugns_pkg::CSR_MIN_X: cfg_in.grid_min[0] = csr_wr_data;
            ugns_pkg::CSR_MIN_Y: cfg_in.grid_min[1] = csr_wr_data;
            ugns_pkg::CSR_MIN_Z: cfg_in.grid_min[2] = csr_wr_data;
            ugns_pkg::CSR_MAX_X: cfg_in.grid_max[0] = csr_wr_data;
            ugns_pkg::CSR_MAX_Y: cfg_in.grid_max[1] = csr_wr_data;
            ugns_pkg::CSR_MAX_Z: cfg_in.grid_max[2] = csr_wr_data;
            ugns_pkg::CSR_EDGE:  cfg_in.cell_edge   = csr_wr_data[ugns_pkg::RAD_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_min  <= '0;
         cfg_ff.grid_max  <= {3{24'd3840}};
         cfg_ff.cell_edge <= 23'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies requests; the queue lets it run ahead of the back end.
   ugns_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .accept_en  (clear_done),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   ugns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end owns the bucket memories and produces every result.
   ugns_back #(
      .CELLS_PER_AXIS (CELLS_PER_AXIS),
      .BUCKET_CAP     (BUCKET_CAP),
      .MAX_HITS       (MAX_HITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (!q_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .clear_done (clear_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // No request may enter while the fill counts are still being cleared.
   assert property (@(posedge clock) disable iff (reset) !clear_done |-> !req_tready)
      else $error("request accepted during the clearing pass");

   // The front end never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue overflow");

   // The back end only pops a queue that holds an item.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue underflow");
`endif

endmodule

/* hdl/ugns_divider.sv */
// Restoring unsigned divider that retires one quotient bit per cycle.
module ugns_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ugns_pkg::DVD_W-1:0] dividend,
   input  logic [ugns_pkg::RAD_W-1:0] divisor,
   output logic                      done,
   output logic [ugns_pkg::DVD_W-1:0] quotient,
   output logic [ugns_pkg::RAD_W-1:0] remainder
);

   localparam int CNT_W = $clog2(ugns_pkg::DVD_W + 1);

   logic [ugns_pkg::DVD_W-1:0] quo_ff, quo_in;
   logic [ugns_pkg::RAD_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ugns_pkg::RAD_W:0]   shifted;
   logic [ugns_pkg::RAD_W:0]   diff;
   logic                       fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[ugns_pkg::DVD_W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(ugns_pkg::DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ugns_pkg::DVD_W-2:0], fits};
         rem_in = fits ? diff[ugns_pkg::RAD_W-1:0] : shifted[ugns_pkg::RAD_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* hdl/ugns_front.sv */
// Front end: takes request transactions, drops unknown kinds, squares the radius.
module ugns_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [ugns_pkg::REQ_W-1:0] req_tdata,
   input  logic [1:0]                 req_tuser,
   input  logic                       accept_en,
   input  logic                       q_full,
   output logic                       q_push,
   output ugns_pkg::item_type         q_item
);

   logic                stage_valid_ff, stage_valid_in;
   ugns_pkg::item_type  stage_ff, stage_in;
   logic                take;
   logic                known;

   always_comb begin
      req_tready = accept_en && (!stage_valid_ff || !q_full);
      take       = req_tvalid && req_tready;
      known      = req_tuser inside {ugns_pkg::KIND_INSERT, ugns_pkg::KIND_REMOVE,
                                     ugns_pkg::KIND_QUERY};
      q_push     = stage_valid_ff && !q_full;

      stage_valid_in = stage_valid_ff;
      if (q_push) begin
         stage_valid_in = 1'b0;
      end
      if (take && known) begin
         stage_valid_in = 1'b1;
      end

      stage_in = stage_ff;
      if (take) begin
         stage_in.kind          = req_tuser;
         stage_in.particle_id   = req_tdata[15:0];
         stage_in.pos_x         = req_tdata[39:16];
         stage_in.pos_y         = req_tdata[63:40];
         stage_in.pos_z         = req_tdata[87:64];
         stage_in.search_radius = req_tdata[110:88];
         stage_in.radius_sq     = ugns_pkg::RR_W'(req_tdata[110:88]) *
                                  ugns_pkg::RR_W'(req_tdata[110:88]);
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign q_item = stage_ff;

endmodule

/* hdl/ugns_queue.sv */
// Two-entry queue between the front end and the back end.
module ugns_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ugns_pkg::item_type push_item,
   input  logic               pop,
   output ugns_pkg::item_type head,
   output logic               full,
   output logic               empty
);

   localparam int PW = $clog2(ugns_pkg::Q_DEPTH);
   localparam int CW = $clog2(ugns_pkg::Q_DEPTH + 1);

   ugns_pkg::item_type slot_ff [ugns_pkg::Q_DEPTH];
   logic [PW-1:0]      wr_ff, wr_in;
   logic [PW-1:0]      rd_ff, rd_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   always_comb begin
      full   = cnt_ff == CW'(ugns_pkg::Q_DEPTH);
      empty  = cnt_ff == '0;
      head   = slot_ff[rd_ff];
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/ugns_back.sv */
// Back end: cell mapping, bucket store, remove and range query sequencer.
module ugns_back #(
   parameter int CELLS_PER_AXIS = 16,
   parameter int BUCKET_CAP     = 8,
   parameter int MAX_HITS       = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ugns_pkg::cfg_type          cfg,
   input  logic                       q_valid,
   input  ugns_pkg::item_type         q_item,
   output logic                       q_pop,
   output logic                       clear_done,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ugns_pkg::RSP_W-1:0] rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int NCELLS = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
   localparam int CW     = $clog2(NCELLS);
   localparam int EAW    = $clog2(NCELLS * BUCKET_CAP);
   localparam int FW     = $clog2(BUCKET_CAP + 1);
   localparam int XW     = $clog2(CELLS_PER_AXIS);
   localparam int NW     = $clog2(CELLS_PER_AXIS + 1);
   localparam int T1W    = $clog2(CELLS_PER_AXIS * CELLS_PER_AXIS);
   localparam int HW     = $clog2(MAX_HITS + 1);
   localparam int PW     = ugns_pkg::POS_W;
   localparam int FLW    = ugns_pkg::DVD_W + 2;

   // Storage
   logic [FW-1:0]       fill_mem [NCELLS];
   ugns_pkg::entry_type ent_mem  [NCELLS * BUCKET_CAP];
   logic [FW-1:0]       fill_rd_ff;
   ugns_pkg::entry_type ent_rd_ff;
   logic                fill_we;
   logic [CW-1:0]       fill_waddr, fill_raddr;
   logic [FW-1:0]       fill_wdata;
   logic                ent_we;
   logic [EAW-1:0]      ent_waddr, ent_raddr;
   ugns_pkg::entry_type ent_wdata;

   // Sequencer state
   ugns_pkg::back_state_type state_ff, state_in;
   ugns_pkg::phase_type      ph_ff, ph_in;
   logic [CW-1:0]            clr_ff, clr_in;
   logic                     clear_done_ff, clear_done_in;
   ugns_pkg::item_type       item_ff, item_in;
   logic [1:0]               ax_ff, ax_in;
   logic                     neg_ff, neg_in;
   logic signed [FLW-1:0]    lo_f_ff, lo_f_in;
   logic [NW-1:0]            n_ff [3];
   logic [NW-1:0]            n_in [3];
   logic [XW-1:0]            cur_ff [3];
   logic [XW-1:0]            cur_in [3];
   logic [XW-1:0]            lo_ff [3];
   logic [XW-1:0]            lo_in [3];
   logic [XW-1:0]            hi_ff [3];
   logic [XW-1:0]            hi_in [3];
   logic                     outside_ff, outside_in;
   logic                     empty_ff, empty_in;
   logic [T1W-1:0]           t1_ff, t1_in;
   logic [CW-1:0]            cell_ff, cell_in;
   logic [EAW-1:0]           base_ff, base_in;
   logic [FW-1:0]            fill_ff, fill_in;
   logic [FW-1:0]            slot_ff, slot_in;
   logic signed [PW:0]       d_ff [3];
   logic signed [PW:0]       d_in [3];
   logic [1:0]               sq_ff, sq_in;
   logic [2*PW-1:0]          prod_ff, prod_in;
   logic [2*PW+1:0]          acc_ff, acc_in;
   logic [ugns_pkg::ID_W-1:0] hit_id_ff, hit_id_in;
   logic [ugns_pkg::ID_W-1:0] pend_ff, pend_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [HW-1:0]            hits_ff, hits_in;
   logic [ugns_pkg::ID_W-1:0] res_id_ff, res_id_in;
   logic [2:0]               res_st_ff, res_st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ugns_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [2:0]               rsp_st_ff, rsp_st_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Divider hookup and per-axis selections
   logic                           div_start, div_done;
   logic [ugns_pkg::DVD_W-1:0]     div_dvd, div_q;
   logic [ugns_pkg::RAD_W-1:0]     div_rem, edge_eff;
   logic signed [PW-1:0]           pos_sel, min_sel, max_sel;
   logic signed [ugns_pkg::DVD_W:0] dvd, rad_s;
   logic signed [FLW-1:0]          q_s, fl, nm1, lo_w, hi_w;
   logic [ugns_pkg::DVD_W:0]       qp1;
   logic signed [2*PW+1:0]         sq_full;
   logic                           out_free;
   logic                           is_query;

   ugns_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (edge_eff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_rem)
   );

   always_comb begin
      edge_eff = (cfg.cell_edge == '0) ? ugns_pkg::RAD_W'(1) : cfg.cell_edge;
      is_query = item_ff.kind == ugns_pkg::KIND_QUERY;
      case (ax_ff)
         2'd0:    pos_sel = $signed(item_ff.pos_x);
         2'd1:    pos_sel = $signed(item_ff.pos_y);
         default: pos_sel = $signed(item_ff.pos_z);
      endcase
      min_sel = $signed(cfg.grid_min[ax_ff]);
      max_sel = $signed(cfg.grid_max[ax_ff]);
      rad_s   = $signed({4'b0, item_ff.search_radius});
      case (ph_ff)
         ugns_pkg::PH_SPAN: dvd = 27'(max_sel) - 27'(min_sel);
         ugns_pkg::PH_LO: begin
            if (is_query) begin
               dvd = 27'(pos_sel) - rad_s - 27'(min_sel);
            end else begin
               dvd = 27'(pos_sel) - 27'(min_sel);
            end
         end
         default: dvd = 27'(pos_sel) + rad_s - 27'(min_sel);
      endcase
      div_dvd = (dvd < 0) ? ugns_pkg::DVD_W'(-dvd) : ugns_pkg::DVD_W'(dvd);

      // Floor division from the unsigned quotient and the stored sign.
      q_s = $signed({2'b00, div_q});
      if (neg_ff) begin
         fl = -q_s - ((div_rem != '0) ? FLW'(1) : FLW'(0));
      end else begin
         fl = q_s;
      end
      qp1  = {1'b0, div_q} + 27'd1;
      nm1  = $signed(FLW'(n_ff[ax_ff])) - FLW'(1);
      lo_w = (lo_f_ff < 0) ? FLW'(0) : lo_f_ff;
      hi_w = (fl > nm1) ? nm1 : fl;

      sq_full = d_ff[sq_ff] * d_ff[sq_ff];
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in      = state_ff;
      ph_in         = ph_ff;
      clr_in        = clr_ff;
      clear_done_in = clear_done_ff;
      item_in       = item_ff;
      ax_in         = ax_ff;
      neg_in        = neg_ff;
      lo_f_in       = lo_f_ff;
      n_in          = n_ff;
      cur_in        = cur_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      outside_in    = outside_ff;
      empty_in      = empty_ff;
      t1_in         = t1_ff;
      cell_in       = cell_ff;
      base_in       = base_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      hit_id_in     = hit_id_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      hits_in       = hits_ff;
      res_id_in     = res_id_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_st_in     = rsp_st_ff;
      rsp_last_in   = rsp_last_ff;

      q_pop      = 1'b0;
      div_start  = 1'b0;
      fill_we    = 1'b0;
      fill_waddr = cell_ff;
      fill_wdata = '0;
      fill_raddr = cell_ff;
      ent_we     = 1'b0;
      ent_waddr  = base_ff + EAW'(slot_ff);
      ent_wdata  = ent_rd_ff;
      ent_raddr  = base_ff + EAW'(slot_ff);

      case (state_ff)
         ugns_pkg::S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            clr_in     = clr_ff + CW'(1);
            if (clr_ff == CW'(NCELLS - 1)) begin
               clear_done_in = 1'b1;
               state_in      = ugns_pkg::S_IDLE;
            end
         end
         ugns_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               item_in       = q_item;
               ax_in         = 2'd0;
               ph_in         = ugns_pkg::PH_SPAN;
               outside_in    = 1'b0;
               empty_in      = 1'b0;
               pend_valid_in = 1'b0;
               hits_in       = '0;
               state_in      = ugns_pkg::S_DIV_GO;
            end
         end
         ugns_pkg::S_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = dvd < 0;
            state_in  = ugns_pkg::S_DIV_WAIT;
         end
         ugns_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               state_in = ugns_pkg::S_DIV_GO;
               case (ph_ff)
                  ugns_pkg::PH_SPAN: begin
                     if (neg_ff) begin
                        n_in[ax_ff] = '0;
                     end else if (qp1 > 27'(CELLS_PER_AXIS)) begin
                        n_in[ax_ff] = NW'(CELLS_PER_AXIS);
                     end else begin
                        n_in[ax_ff] = NW'(qp1);
                     end
                     ph_in = ugns_pkg::PH_LO;
                  end
                  ugns_pkg::PH_LO: begin
                     if (is_query) begin
                        lo_f_in = fl;
                        ph_in   = ugns_pkg::PH_HI;
                     end else begin
                        if (!(pos_sel > min_sel && pos_sel < max_sel &&
                              27'(div_q) < 27'(n_ff[ax_ff]))) begin
                           outside_in = 1'b1;
                        end
                        cur_in[ax_ff] = div_q[XW-1:0];
                        ph_in         = ugns_pkg::PH_SPAN;
                        ax_in         = ax_ff + 2'd1;
                        if (ax_ff == 2'd2) begin
                           state_in = ugns_pkg::S_ROUTE;
                        end
                     end
                  end
                  default: begin
                     if (lo_w > hi_w) begin
                        empty_in = 1'b1;
                     end
                     lo_in[ax_ff] = lo_w[XW-1:0];
                     hi_in[ax_ff] = hi_w[XW-1:0];
                     ph_in        = ugns_pkg::PH_SPAN;
                     ax_in        = ax_ff + 2'd1;
                     if (ax_ff == 2'd2) begin
                        state_in = ugns_pkg::S_ROUTE;
                     end
                  end
               endcase
            end
         end
         ugns_pkg::S_ROUTE: begin
            res_id_in = item_ff.particle_id;
            if (is_query) begin
               if (empty_ff) begin
                  res_st_in = ugns_pkg::ST_NO_HITS;
                  state_in  = ugns_pkg::S_RESULT;
               end else begin
                  cur_in   = lo_ff;
                  state_in = ugns_pkg::S_CELL_A;
               end
            end else if (outside_ff) begin
               res_st_in = ugns_pkg::ST_OUTSIDE;
               state_in  = ugns_pkg::S_RESULT;
            end else begin
               state_in = ugns_pkg::S_CELL_A;
            end
         end
         ugns_pkg::S_CELL_A: begin
            t1_in    = T1W'(cur_ff[0]) * T1W'(n_ff[1]) + T1W'(cur_ff[1]);
            state_in = ugns_pkg::S_CELL_B;
         end
         ugns_pkg::S_CELL_B: begin
            cell_in  = CW'(t1_ff) * CW'(n_ff[2]) + CW'(cur_ff[2]);
            state_in = ugns_pkg::S_FILL_RD;
         end
         ugns_pkg::S_FILL_RD: begin
            base_in  = EAW'(cell_ff) * EAW'(BUCKET_CAP);
            state_in = ugns_pkg::S_FILL_CHK;
         end
         ugns_pkg::S_FILL_CHK: begin
            fill_in = fill_rd_ff;
            slot_in = '0;
            case (item_ff.kind)
               ugns_pkg::KIND_INSERT: begin
                  state_in = ugns_pkg::S_RESULT;
                  if (fill_rd_ff >= FW'(BUCKET_CAP)) begin
                     res_st_in = ugns_pkg::ST_FULL;
                  end else begin
                     ent_we                = 1'b1;
                     ent_waddr             = base_ff + EAW'(fill_rd_ff);
                     ent_wdata.particle_id = item_ff.particle_id;
                     ent_wdata.pos_x       = item_ff.pos_x;
                     ent_wdata.pos_y       = item_ff.pos_y;
                     ent_wdata.pos_z       = item_ff.pos_z;
                     fill_we               = 1'b1;
                     fill_wdata            = fill_rd_ff + FW'(1);
                     res_st_in             = ugns_pkg::ST_OK;
                  end
               end
               ugns_pkg::KIND_REMOVE: begin
                  if (fill_rd_ff == '0) begin
                     res_st_in = ugns_pkg::ST_NOT_PRESENT;
                     state_in  = ugns_pkg::S_RESULT;
                  end else begin
                     state_in = ugns_pkg::S_REM_RD;
                  end
               end
               default: begin
                  if (fill_rd_ff == '0) begin
                     state_in = ugns_pkg::S_QRY_NEXT;
                  end else begin
                     state_in = ugns_pkg::S_QRY_RD;
                  end
               end
            endcase
         end
         ugns_pkg::S_REM_RD: begin
            state_in = ugns_pkg::S_REM_CMP;
         end
         ugns_pkg::S_REM_CMP: begin
            if (ent_rd_ff.particle_id == item_ff.particle_id) begin
               // Fetch the bucket's last entry to move into the freed slot.
               ent_raddr = base_ff + EAW'(fill_ff) - EAW'(1);
               state_in  = ugns_pkg::S_REM_MOVE;
            end else if (slot_ff + FW'(1) == fill_ff) begin
               res_st_in = ugns_pkg::ST_NOT_PRESENT;
               state_in  = ugns_pkg::S_RESULT;
            end else begin
               slot_in  = slot_ff + FW'(1);
               state_in = ugns_pkg::S_REM_RD;
            end
         end
         ugns_pkg::S_REM_MOVE: begin
            ent_we     = 1'b1;
            fill_we    = 1'b1;
            fill_wdata = fill_ff - FW'(1);
            res_st_in  = ugns_pkg::ST_OK;
            state_in   = ugns_pkg::S_RESULT;
         end
         ugns_pkg::S_QRY_RD: begin
            state_in = ugns_pkg::S_QRY_DIFF;
         end
         ugns_pkg::S_QRY_DIFF: begin
            d_in[0]   = $signed({ent_rd_ff.pos_x[PW-1], ent_rd_ff.pos_x}) -
                        $signed({item_ff.pos_x[PW-1], item_ff.pos_x});
            d_in[1]   = $signed({ent_rd_ff.pos_y[PW-1], ent_rd_ff.pos_y}) -
                        $signed({item_ff.pos_y[PW-1], item_ff.pos_y});
            d_in[2]   = $signed({ent_rd_ff.pos_z[PW-1], ent_rd_ff.pos_z}) -
                        $signed({item_ff.pos_z[PW-1], item_ff.pos_z});
            hit_id_in = ent_rd_ff.particle_id;
            sq_in     = 2'd0;
            prod_in   = '0;
            acc_in    = '0;
            state_in  = ugns_pkg::S_QRY_SQ;
         end
         ugns_pkg::S_QRY_SQ: begin
            prod_in = sq_full[2*PW-1:0];
            acc_in  = acc_ff + (2*PW+2)'(prod_ff);
            sq_in   = sq_ff + 2'd1;
            if (sq_ff == 2'd2) begin
               state_in = ugns_pkg::S_QRY_SUM;
            end
         end
         ugns_pkg::S_QRY_SUM: begin
            acc_in   = acc_ff + (2*PW+2)'(prod_ff);
            state_in = ugns_pkg::S_QRY_CMP;
         end
         ugns_pkg::S_QRY_CMP: begin
            state_in = ugns_pkg::S_QRY_ADV;
            if (acc_ff < (2*PW+2)'(item_ff.radius_sq)) begin
               if (hits_ff == HW'(MAX_HITS)) begin
                  res_id_in = pend_ff;
                  res_st_in = ugns_pkg::ST_TRUNCATED;
                  state_in  = ugns_pkg::S_RESULT;
               end else if (pend_valid_ff) begin
                  state_in = ugns_pkg::S_QRY_EMIT;
               end else begin
                  pend_in       = hit_id_ff;
                  pend_valid_in = 1'b1;
                  hits_in       = hits_ff + HW'(1);
               end
            end
         end
         ugns_pkg::S_QRY_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = pend_ff;
               rsp_st_in    = ugns_pkg::ST_HIT;
               rsp_last_in  = 1'b0;
               pend_in      = hit_id_ff;
               hits_in      = hits_ff + HW'(1);
               state_in     = ugns_pkg::S_QRY_ADV;
            end
         end
         ugns_pkg::S_QRY_ADV: begin
            if (slot_ff + FW'(1) < fill_ff) begin
               slot_in  = slot_ff + FW'(1);
               state_in = ugns_pkg::S_QRY_RD;
            end else begin
               state_in = ugns_pkg::S_QRY_NEXT;
            end
         end
         ugns_pkg::S_QRY_NEXT: begin
            state_in = ugns_pkg::S_CELL_A;
            if (cur_ff[2] != hi_ff[2]) begin
               cur_in[2] = cur_ff[2] + XW'(1);
            end else if (cur_ff[1] != hi_ff[1]) begin
               cur_in[1] = cur_ff[1] + XW'(1);
               cur_in[2] = lo_ff[2];
            end else if (cur_ff[0] != hi_ff[0]) begin
               cur_in[0] = cur_ff[0] + XW'(1);
               cur_in[1] = lo_ff[1];
               cur_in[2] = lo_ff[2];
            end else begin
               state_in = ugns_pkg::S_QRY_END;
            end
         end
         ugns_pkg::S_QRY_END: begin
            state_in = ugns_pkg::S_RESULT;
            if (pend_valid_ff) begin
               res_id_in = pend_ff;
               res_st_in = ugns_pkg::ST_HIT;
            end else begin
               res_id_in = item_ff.particle_id;
               res_st_in = ugns_pkg::ST_NO_HITS;
            end
         end
         ugns_pkg::S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_st_in    = res_st_ff;
               rsp_last_in  = 1'b1;
               state_in     = ugns_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ugns_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_mem[fill_raddr];
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rd_ff <= ent_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      ph_ff     <= ph_in;
      ax_ff     <= ax_in;
      neg_ff    <= neg_in;
      lo_f_ff   <= lo_f_in;
      n_ff      <= n_in;
      cur_ff    <= cur_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      outside_ff <= outside_in;
      empty_ff  <= empty_in;
      t1_ff     <= t1_in;
      cell_ff   <= cell_in;
      base_ff   <= base_in;
      fill_ff   <= fill_in;
      slot_ff   <= slot_in;
      d_ff      <= d_in;
      sq_ff     <= sq_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      hit_id_ff <= hit_id_in;
      pend_ff   <= pend_in;
      hits_ff   <= hits_in;
      res_id_ff <= res_id_in;
      res_st_ff <= res_st_in;
      rsp_id_ff <= rsp_id_in;
      rsp_st_ff <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= ugns_pkg::S_CLEAR;
         clr_ff        <= '0;
         clear_done_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         clear_done_ff <= clear_done_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign clear_done = clear_done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_st_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the uniform grid neighbor search core.
`timescale 1ns / 1ps

module tb;

   localparam int CELLS       = 16;
   localparam int CAP         = 8;
   localparam int HIT_LIMIT   = 64;
   localparam int NUM_CELLS   = CELLS * CELLS * CELLS;
   localparam int SETTLE      = 2000;    // extra wait at the end of each drain
   localparam int STALL_LIMIT = 400000;  // cycles with no transaction on either side
   localparam int LONG_HOLD   = 3000;
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct {
      logic [15:0] id;
      logic [2:0]  status;
      logic        last;
   } answer_type;

   typedef struct {
      logic [15:0] id;
      logic [23:0] px, py, pz;
   } particle_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [ugns_pkg::REQ_W-1:0]  req_tdata = '0;
   logic [1:0]                  req_tuser = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [ugns_pkg::RSP_W-1:0]  rsp_tdata;
   logic                        rsp_tlast;
   logic                        csr_wr_en = 1'b0;
   logic [2:0]                  csr_index = '0;
   logic [ugns_pkg::POS_W-1:0]  csr_wr_data = '0;

   // Shadow copy of the grid: configuration, bucket fill counts and entries.
   longint      grid_lo[3], grid_hi[3], edge_len;
   int          fill_count[NUM_CELLS];
   logic [15:0] slot_id[NUM_CELLS*CAP];
   longint      slot_pos[NUM_CELLS*CAP][3];

   answer_type    pending_answers[$];
   particle_type  stored_pool[$];

   bit          quiet = 1'b0;
   int          hold_asked = 0, hold_served = 0;
   int          mismatches = 0, requests_sent = 0, answers_seen = 0;
   int          hits_seen = 0, truncations = 0, full_seen = 0;
   int          idle_cycles = 0;

   uniform_grid_neighbor_search_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sx24(logic [23:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint cell_len();
      return (edge_len == 0) ? 1 : edge_len;
   endfunction

   // Cells along one axis, capped at the grid size, zero for an inverted box.
   function automatic longint cells_on_axis(int a);
      longint span, n;
      span = grid_hi[a] - grid_lo[a];
      if (span < 0) return 0;
      n = span / cell_len() + 1;
      return (n > CELLS) ? CELLS : n;
   endfunction

   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   // Cell number of a point, or -1 when it is not strictly inside the grid.
   function automatic longint home_cell(longint p[3]);
      longint c[3], n[3];
      for (int a = 0; a < 3; a++) begin
         n[a] = cells_on_axis(a);
         if (!(p[a] > grid_lo[a] && p[a] < grid_hi[a])) return -1;
         c[a] = (p[a] - grid_lo[a]) / cell_len();
         if (c[a] >= n[a]) return -1;
      end
      return c[0] * n[1] * n[2] + c[1] * n[2] + c[2];
   endfunction

   function automatic void expect_answer(logic [15:0] id, logic [2:0] st, logic lst);
      answer_type e;
      e.id = id; e.status = st; e.last = lst;
      pending_answers = {pending_answers, e};
   endfunction

   // Apply one accepted request to the shadow grid and queue its answers.
   function automatic void search_grid(logic [1:0] kind, logic [15:0] id, longint p[3],
                                       longint r);
      longint cell_no, lo[3], hi[3], n[3], rr, d, dd;
      int base, fill, hits, first;
      bit trunc, empty, found;
      if (kind == ugns_pkg::KIND_INSERT || kind == ugns_pkg::KIND_REMOVE) begin
         cell_no = home_cell(p);
         if (cell_no < 0) begin
            expect_answer(id, ugns_pkg::ST_OUTSIDE, 1'b1);
            return;
         end
         base = int'(cell_no) * CAP;
         fill = fill_count[cell_no];
         if (kind == ugns_pkg::KIND_INSERT) begin
            if (fill >= CAP) begin
               expect_answer(id, ugns_pkg::ST_FULL, 1'b1);
               return;
            end
            slot_id[base + fill] = id;
            for (int a = 0; a < 3; a++) slot_pos[base + fill][a] = p[a];
            fill_count[cell_no] = fill + 1;
            expect_answer(id, ugns_pkg::ST_OK, 1'b1);
            return;
         end
         found = 1'b0;
         for (int s = 0; s < fill && !found; s++) begin
            if (slot_id[base + s] == id) begin
               // The bucket's last entry moves into the freed slot.
               slot_id[base + s] = slot_id[base + fill - 1];
               for (int a = 0; a < 3; a++) slot_pos[base + s][a] = slot_pos[base + fill - 1][a];
               fill_count[cell_no] = fill - 1;
               found = 1'b1;
            end
         end
         expect_answer(id, found ? ugns_pkg::ST_OK : ugns_pkg::ST_NOT_PRESENT, 1'b1);
         return;
      end
      if (kind != ugns_pkg::KIND_QUERY) return;
      rr = r * r;
      hits = 0;
      trunc = 1'b0;
      empty = 1'b0;
      first = pending_answers.size();
      for (int a = 0; a < 3; a++) begin
         n[a] = cells_on_axis(a);
         lo[a] = floor_quot(p[a] - r - grid_lo[a], cell_len());
         hi[a] = floor_quot(p[a] + r - grid_lo[a], cell_len());
         if (lo[a] < 0) lo[a] = 0;
         if (hi[a] > n[a] - 1) hi[a] = n[a] - 1;
         if (lo[a] > hi[a]) empty = 1'b1;
      end
      if (!empty) begin
         for (longint x = lo[0]; x <= hi[0] && !trunc; x++)
            for (longint y = lo[1]; y <= hi[1] && !trunc; y++)
               for (longint z = lo[2]; z <= hi[2] && !trunc; z++) begin
                  cell_no = x * n[1] * n[2] + y * n[2] + z;
                  base = int'(cell_no) * CAP;
                  for (int s = 0; s < fill_count[cell_no] && !trunc; s++) begin
                     dd = 0;
                     for (int a = 0; a < 3; a++) begin
                        d = slot_pos[base + s][a] - p[a];
                        dd += d * d;
                     end
                     if (dd < rr) begin
                        if (hits >= HIT_LIMIT) trunc = 1'b1;
                        else begin
                           expect_answer(slot_id[base + s], ugns_pkg::ST_HIT, 1'b0);
                           hits++;
                        end
                     end
                  end
               end
      end
      if (hits == 0) begin
         expect_answer(id, ugns_pkg::ST_NO_HITS, 1'b1);
         return;
      end
      pending_answers[first + hits - 1].last = 1'b1;
      if (trunc) pending_answers[first + hits - 1].status = ugns_pkg::ST_TRUNCATED;
   endfunction

   // Offer one request, possibly after a random gap, and wait for its transaction.
   task automatic send_request(logic [1:0] kind, logic [15:0] id, logic [23:0] px,
                               logic [23:0] py, logic [23:0] pz, logic [22:0] r);
      longint p[3];
      particle_type q;
      if (!quiet && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, r, pz, py, px, id};
      do @(posedge clock); while (!req_tready);
      p[0] = sx24(px); p[1] = sx24(py); p[2] = sx24(pz);
      search_grid(kind, id, p, longint'(r));
      requests_sent++;
      if (kind == ugns_pkg::KIND_INSERT) begin
         q.id = id; q.px = px; q.py = py; q.pz = pz;
         stored_pool = {stored_pool, q};
      end
   endtask

   // Stop offering and wait until every queued answer has been returned.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx < ugns_pkg::CSR_MAX_X) grid_lo[idx] = sx24(val);
      else if (idx < ugns_pkg::CSR_EDGE) grid_hi[idx - ugns_pkg::CSR_MAX_X] = sx24(val);
      else edge_len = longint'(val[22:0]);
   endtask

   task automatic set_grid(logic [23:0] lo, logic [23:0] hi, logic [22:0] e);
      drain();
      write_reg(ugns_pkg::CSR_MIN_X, lo);
      write_reg(ugns_pkg::CSR_MIN_Y, lo);
      write_reg(ugns_pkg::CSR_MIN_Z, lo);
      write_reg(ugns_pkg::CSR_MAX_X, hi);
      write_reg(ugns_pkg::CSR_MAX_Y, hi);
      write_reg(ugns_pkg::CSR_MAX_Z, hi);
      write_reg(ugns_pkg::CSR_EDGE, {1'b0, e});
      @(posedge clock);
   endtask

   // A coordinate strictly inside the current box on one axis, usually.
   function automatic logic [23:0] coord_inside(int a);
      longint lo, hi;
      lo = grid_lo[a] + 1;
      hi = grid_hi[a] - 1;
      if (hi > grid_lo[a] + longint'(CELLS) * cell_len() - 1)
         hi = grid_lo[a] + longint'(CELLS) * cell_len() - 1;
      if (hi < lo || $urandom_range(15) == 0) return 24'($urandom);
      return 24'(lo + longint'($urandom_range(32'(hi - lo))));
   endfunction

   // Directed requests: boundaries, a full bucket, removes of every outcome,
   // queries with hits, none, zero radius, and an unknown kind.
   task automatic test_basic_ops();
      for (int i = 0; i < 9; i++)
         send_request(ugns_pkg::KIND_INSERT,
                      (i == 0) ? 16'h0000 : (i == 8) ? 16'hFFFF : 16'(100 + i),
                      24'd300 + 24'(i), 24'd310, 24'd320, 23'd0);
      send_request(ugns_pkg::KIND_INSERT, 16'd100 + 16'd3, 24'd600, 24'd600, 24'd600, 23'd0);
      send_request(ugns_pkg::KIND_INSERT, 16'd7, 24'd0, 24'd100, 24'd100, 23'd0);
      send_request(ugns_pkg::KIND_INSERT, 16'd8, 24'd3840, 24'd100, 24'd100, 23'd0);
      send_request(ugns_pkg::KIND_INSERT, 16'd9, 24'd3839, 24'd1, 24'd3839, 23'd0);
      send_request(ugns_pkg::KIND_INSERT, 16'd10, 24'h800000, 24'h7FFFFF, 24'd5, 23'd0);
      send_request(ugns_pkg::KIND_REMOVE, 16'd103, 24'd303, 24'd310, 24'd320, 23'd0);
      send_request(ugns_pkg::KIND_REMOVE, 16'd999, 24'd303, 24'd310, 24'd320, 23'd0);
      send_request(ugns_pkg::KIND_REMOVE, 16'd103, 24'hFFFFFF, 24'd310, 24'd320, 23'd0);
      send_request(ugns_pkg::KIND_QUERY, 16'd1, 24'd305, 24'd310, 24'd320, 23'd64);
      send_request(ugns_pkg::KIND_QUERY, 16'd2, 24'd2000, 24'd2000, 24'd2000, 23'd10);
      send_request(ugns_pkg::KIND_QUERY, 16'd3, 24'd300, 24'd310, 24'd320, 23'd0);
      send_request(ugns_pkg::KIND_QUERY, 16'd4, 24'd3839, 24'd1, 24'd3839, 23'h7FFFFF);
      send_request(KIND_NONE, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF);
      send_request(ugns_pkg::KIND_QUERY, 16'd5, 24'd600, 24'd600, 24'd600, 23'd256);
   endtask

   // Fill a 3x3 block of cells to capacity and query its middle, so that more
   // than the hit limit lies inside the radius.
   task automatic test_truncation();
      for (int cx = 5; cx < 8; cx++)
         for (int cy = 5; cy < 8; cy++)
            for (int k = 0; k < CAP; k++)
               send_request(ugns_pkg::KIND_INSERT, 16'($urandom),
                            24'(cx * 256 + $urandom_range(1, 255)),
                            24'(cy * 256 + $urandom_range(1, 255)),
                            24'(5 * 256 + $urandom_range(1, 255)), 23'($urandom));
      send_request(ugns_pkg::KIND_QUERY, 16'hABCD, 24'd1664, 24'd1664, 24'd1408, 23'd768);
   endtask

   // Random mix of well-formed traffic with some noise.
   task automatic test_random_mix(int count);
      int pick;
      particle_type q;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_request(ugns_pkg::KIND_INSERT, 16'($urandom), coord_inside(0),
                         coord_inside(1), coord_inside(2), 23'($urandom));
         end else if (pick < 60 && stored_pool.size() != 0) begin
            q = stored_pool[$urandom_range(stored_pool.size() - 1)];
            send_request(ugns_pkg::KIND_REMOVE, q.id, q.px, q.py, q.pz, 23'($urandom));
         end else if (pick < 90) begin
            if (stored_pool.size() != 0 && $urandom_range(1) == 0) begin
               q = stored_pool[$urandom_range(stored_pool.size() - 1)];
               send_request(ugns_pkg::KIND_QUERY, 16'($urandom), q.px, q.py, q.pz,
                            23'($urandom_range(2 * 32'(cell_len()))));
            end else begin
               send_request(ugns_pkg::KIND_QUERY, 16'($urandom), coord_inside(0),
                            coord_inside(1), coord_inside(2),
                            23'($urandom_range(4 * 32'(cell_len()))));
            end
         end else if (pick < 97) begin
            send_request(2'($urandom_range(2)), 16'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom), ($urandom_range(3) == 0) ? 23'($urandom) :
                         23'($urandom_range(1024)));
         end else begin
            send_request(KIND_NONE, 16'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom), 23'($urandom));
            i--;
         end
      end
   endtask

   // Hold the result side off for a long stretch while requests keep coming,
   // pause the request side until everything has been answered, then send more.
   task automatic test_backpressure();
      hold_asked++;
      test_random_mix(10);
      drain();
      test_random_mix(5);
   endtask

   // Result side: random stall bursts, a long hold on request, none when quiet.
   always @(posedge clock) begin : rsp_ready_gen
      int stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_asked != hold_served) begin
         rsp_tready <= 1'b0;
         stall_left = LONG_HOLD;
         hold_served++;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: every transaction is compared with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      answer_type e;
      logic [15:0] got_id;
      logic [2:0]  got_st;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_id = rsp_tdata[15:0];
         got_st = rsp_tdata[18:16];
         answers_seen++;
         if (got_st == ugns_pkg::ST_HIT || got_st == ugns_pkg::ST_TRUNCATED) hits_seen++;
         if (got_st == ugns_pkg::ST_TRUNCATED) truncations++;
         if (got_st == ugns_pkg::ST_FULL) full_seen++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected result: id %h status %0d last %b",
                        $realtime, got_id, got_st, rsp_tlast);
         end else begin
            e = pending_answers.pop_front();
            if (e.id !== got_id || e.status !== got_st || e.last !== rsp_tlast) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t mismatch: expected id %h status %0d last %b, ",
                           $realtime, e.id, e.status, e.last,
                           "got id %h status %0d last %b", got_id, got_st, rsp_tlast);
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      for (int a = 0; a < 3; a++) begin
         grid_lo[a] = 0;
         grid_hi[a] = 3840;
      end
      edge_len = 256;
      foreach (fill_count[c]) fill_count[c] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_truncation();
      test_random_mix(15);
      test_backpressure();
      // Offset box with larger cells; earlier entries stay where they are.
      set_grid(-24'sd2560, 24'd2560, 23'd512);
      test_random_mix(15);
      // Zero edge behaves as an edge of one.
      set_grid(24'd0, 24'd4, 23'd0);
      test_random_mix(8);
      // Widest box and largest edge.
      set_grid(24'h800000, 24'h7FFFFF, 23'h7FFFFF);
      test_random_mix(8);
      // Inverted box: everything lies outside.
      set_grid(24'd100, -24'sd100, 23'd1);
      test_random_mix(5);
      set_grid(24'd0, 24'd3840, 23'd256);
      quiet = 1'b1;
      test_random_mix(15);
      drain();

      $display("covered %0d requests over five grid settings, %0d results", requests_sent,
               answers_seen);
      $display("hits %0d, truncated queries %0d, full buckets %0d", hits_seen, truncations,
               full_seen);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/ugns_pkg.sv
hdl/ugns_divider.sv
hdl/ugns_front.sv
hdl/ugns_queue.sv
hdl/ugns_back.sv
hdl/uniform_grid_neighbor_search_core.sv
tb/sv/tb.sv
